// File: rtl/rcps_pkg.sv
package rcps_pkg;

   localparam int NumDests   = 3;
   localparam int RetryLimit = 5;
   localparam int DestW      = (NumDests > 1) ? $clog2(NumDests) : 1;

   localparam logic [7:0] CH_DLE = 8'h10;
   localparam logic [7:0] CH_STX = 8'h02;
   localparam logic [7:0] CH_ETX = 8'h03;
   localparam logic [7:0] CH_ACK = 8'h06;
   localparam logic [7:0] CH_NAK = 8'h15;
   localparam logic [7:0] CMD_INTERROGATE = 8'h01;
   localparam logic [7:0] CMD_CONNECT     = 8'h02;
   localparam logic [7:0] CMD_TALLY       = 8'h03;
   localparam logic [7:0] CMD_CONNECTED   = 8'h04;
   localparam logic [7:0] BYTE_COUNT_FIELD = 8'h05;

   localparam logic [0:0] CSR_MASK_LOW  = 1'b0;
   localparam logic [0:0] CSR_MASK_HIGH = 1'b1;

   typedef enum logic [2:0] {
      PH_PAIR0, PH_PAIR1, PH_CMD, PH_INTERROG,
      PH_CONN_HEAD, PH_CONN_TAIL, PH_SKIP, PH_SKIP_DLE
   } phase_type;

   typedef enum logic [1:0] {
      JOB_NAK, JOB_RESEND, JOB_ACK_FRAME
   } job_kind_type;

   // One command from parser to emitter.
   typedef struct packed {
      job_kind_type kind;
      logic [7:0]   cmd;
      logic [7:0]   dest;
      logic [7:0]   src;
   } job_type;

   localparam int JobW = $bits(job_type);

   typedef struct packed {
      logic       valid;
      logic [3:0] len;
   } frame_info_type;

endpackage

// File: rtl/rcps_if.sv
interface rcps_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface rcps_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] tx_byte;
   logic       tx_last;
   modport source (output valid, output tx_byte, output tx_last, input ready);
   modport sink (input valid, input tx_byte, input tx_last, output ready);
endinterface

interface rcps_csr_if;
   logic        valid;
   logic        ready;
   logic [0:0]  index;
   logic [63:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/rcps_front.sv
module rcps_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [7:0]           in_byte,
   input  logic [127:0]         mask,
   output logic                 job_valid,
   input  logic                 job_ready,
   output rcps_pkg::job_type    job
);

   rcps_pkg::phase_type phase_ff, phase_in;
   logic [3:0] count_ff, count_in;
   logic [7:0] first_ff, first_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] dest_ff, dest_in;
   logic [7:0] src_ff, src_in;
   logic [2:0] retries_ff, retries_in;
   logic       have_frame_ff, have_frame_in;
   logic [7:0] tally_ff [rcps_pkg::NumDests];
   logic [7:0] tally_in [rcps_pkg::NumDests];
   logic       fire;
   logic [7:0] sum_next;
   logic       present;

   assign in_ready = job_ready;
   assign fire = in_valid && in_ready;
   assign sum_next = sum_ff + in_byte;

   always_comb begin
      present = 1'b0;
      if (src_ff >= 8'd2 && src_ff <= 8'd127) begin
         present = mask[src_ff[6:0]];
      end
   end

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      first_in = first_ff;
      sum_in = sum_ff;
      dest_in = dest_ff;
      src_in = src_ff;
      retries_in = retries_ff;
      have_frame_in = have_frame_ff;
      tally_in = tally_ff;
      job_valid = 1'b0;
      job = '{kind: rcps_pkg::JOB_NAK, cmd: 8'h00, dest: dest_ff, src: src_ff};
      if (fire) begin
         case (phase_ff)
            rcps_pkg::PH_PAIR0: begin
               first_in = in_byte;
               phase_in = rcps_pkg::PH_PAIR1;
            end
            rcps_pkg::PH_PAIR1: begin
               phase_in = rcps_pkg::PH_PAIR0;
               if (first_ff == rcps_pkg::CH_DLE) begin
                  if (in_byte == rcps_pkg::CH_ACK) begin
                     retries_in = '0;
                  end else if (in_byte == rcps_pkg::CH_NAK) begin
                     if (retries_ff != '0) begin
                        retries_in = retries_ff - 3'd1;
                        if (have_frame_ff) begin
                           job_valid = 1'b1;
                           job.kind = rcps_pkg::JOB_RESEND;
                        end
                     end
                  end else if (in_byte == rcps_pkg::CH_STX) begin
                     phase_in = rcps_pkg::PH_CMD;
                  end
               end
            end
            rcps_pkg::PH_CMD: begin
               count_in = '0;
               sum_in = in_byte;
               if (in_byte == rcps_pkg::CMD_INTERROGATE) phase_in = rcps_pkg::PH_INTERROG;
               else if (in_byte == rcps_pkg::CMD_CONNECT) phase_in = rcps_pkg::PH_CONN_HEAD;
               else if (in_byte == rcps_pkg::CH_DLE) phase_in = rcps_pkg::PH_SKIP_DLE;
               else phase_in = rcps_pkg::PH_SKIP;
            end
            rcps_pkg::PH_INTERROG: begin
               count_in = count_ff + 4'd1;
               if (count_ff <= 4'd4) sum_in = sum_next;
               if (count_ff == 4'd2) dest_in = in_byte;
               if (count_ff == 4'd6) begin
                  phase_in = rcps_pkg::PH_PAIR0;
                  job_valid = 1'b1;
                  if (sum_ff == 8'h00) begin
                     job.kind = rcps_pkg::JOB_ACK_FRAME;
                     job.cmd = rcps_pkg::CMD_TALLY;
                     job.src = (dest_ff < 8'(rcps_pkg::NumDests)) ?
                               tally_ff[dest_ff[rcps_pkg::DestW-1:0]] : 8'h00;
                     retries_in = 3'(rcps_pkg::RetryLimit);
                     have_frame_in = 1'b1;
                  end
               end
            end
            rcps_pkg::PH_CONN_HEAD: begin
               count_in = count_ff + 4'd1;
               sum_in = sum_next;
               if (count_ff == 4'd2) dest_in = in_byte;
               if (count_ff == 4'd3) begin
                  src_in = in_byte;
                  phase_in = rcps_pkg::PH_CONN_TAIL;
                  if (in_byte == rcps_pkg::CH_DLE) begin
                     count_in = 4'd3;
                     sum_in = sum_ff;
                  end
               end
            end
            rcps_pkg::PH_CONN_TAIL: begin
               count_in = count_ff + 4'd1;
               if (count_ff <= 4'd5) sum_in = sum_next;
               if (count_ff == 4'd3) src_in = in_byte;
               if (count_ff == 4'd7) begin
                  phase_in = rcps_pkg::PH_PAIR0;
                  job_valid = 1'b1;
                  if (sum_ff == 8'h00) begin
                     job.kind = rcps_pkg::JOB_ACK_FRAME;
                     job.cmd = rcps_pkg::CMD_CONNECTED;
                     if (dest_ff < 8'(rcps_pkg::NumDests)) begin
                        tally_in[dest_ff[rcps_pkg::DestW-1:0]] = present ? src_ff : 8'h00;
                     end
                     retries_in = 3'(rcps_pkg::RetryLimit);
                     have_frame_in = 1'b1;
                  end
               end
            end
            rcps_pkg::PH_SKIP: begin
               if (in_byte == rcps_pkg::CH_DLE) phase_in = rcps_pkg::PH_SKIP_DLE;
            end
            rcps_pkg::PH_SKIP_DLE: begin
               phase_in = (in_byte == rcps_pkg::CH_ETX) ? rcps_pkg::PH_PAIR0 : rcps_pkg::PH_SKIP;
            end
            default: phase_in = rcps_pkg::PH_PAIR0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      first_ff <= first_in;
      sum_ff <= sum_in;
      dest_ff <= dest_in;
      src_ff <= src_in;
      count_ff <= count_in;
      if (reset) begin
         phase_ff <= rcps_pkg::PH_PAIR0;
         retries_ff <= '0;
         have_frame_ff <= 1'b0;
         for (int i = 0; i < rcps_pkg::NumDests; i++) tally_ff[i] <= 8'h00;
      end else begin
         phase_ff <= phase_in;
         retries_ff <= retries_in;
         have_frame_ff <= have_frame_in;
         tally_ff <= tally_in;
      end
   end

`ifndef SYNTHESIS
   a_retry_bound: assert property (@(posedge clock) disable iff (reset)
      retries_ff <= 3'(rcps_pkg::RetryLimit))
      else $error("retry count above limit");
   a_resend_needs_frame: assert property (@(posedge clock) disable iff (reset)
      job_valid && job.kind == rcps_pkg::JOB_RESEND |-> have_frame_ff)
      else $error("resend without frame");
   a_retry_reload: assert property (@(posedge clock) disable iff (reset)
      fire && job_valid && job.kind == rcps_pkg::JOB_ACK_FRAME
      |=> retries_ff == 3'(rcps_pkg::RetryLimit))
      else $error("retries not reloaded");
`endif

endmodule

// File: rtl/rcps_back.sv
module rcps_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   output logic              job_ready,
   input  rcps_pkg::job_type job,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [7:0]        out_byte,
   output logic              out_last
);

   logic [7:0] frame_ff [12];
   logic [7:0] frame_in [12];
   rcps_pkg::frame_info_type info_ff, info_in;
   logic       busy_ff, busy_in;
   logic [3:0] pos_ff, pos_in;
   logic [3:0] end_ff, end_in;
   logic       pre_ff, pre_in;
   logic [7:0] pre_b_ff, pre_b_in;
   logic       send_frame_ff, send_frame_in;
   logic       pre_dle_ff, pre_dle_in;
   logic       pre_hold;
   logic [7:0] cks;
   logic [3:0] k;
   logic       step;

   assign job_ready = !busy_ff;
   assign out_valid = busy_ff;
   assign step = out_valid && out_ready;

   always_comb begin
      cks = 8'h00 - (job.cmd + job.dest + job.src + rcps_pkg::BYTE_COUNT_FIELD);
      frame_in = frame_ff;
      info_in = info_ff;
      busy_in = busy_ff;
      pos_in = pos_ff;
      end_in = end_ff;
      pre_in = pre_ff;
      pre_b_in = pre_b_ff;
      send_frame_in = send_frame_ff;
      k = 4'd6;
      if (step) begin
         if (pre_ff) begin
            pre_in = 1'b0;
            if (!send_frame_ff && !pre_dle_ff) busy_in = 1'b0;
         end else begin
            pos_in = pos_ff + 4'd1;
            if (pos_ff == end_ff) busy_in = 1'b0;
         end
      end
      if (job_valid && job_ready) begin
         busy_in = 1'b1;
         pos_in = '0;
         end_in = info_ff.len - 4'd1;
         case (job.kind)
            rcps_pkg::JOB_NAK: begin
               pre_in = 1'b1;
               pre_b_in = rcps_pkg::CH_NAK;
               send_frame_in = 1'b0;
            end
            rcps_pkg::JOB_RESEND: begin
               pre_in = 1'b0;
               send_frame_in = 1'b1;
            end
            rcps_pkg::JOB_ACK_FRAME: begin
               pre_in = 1'b1;
               pre_b_in = rcps_pkg::CH_ACK;
               send_frame_in = 1'b1;
               frame_in[0] = rcps_pkg::CH_DLE;
               frame_in[1] = rcps_pkg::CH_STX;
               frame_in[2] = job.cmd;
               frame_in[3] = 8'h00;
               frame_in[4] = 8'h00;
               frame_in[5] = job.dest;
               if (job.src == rcps_pkg::CH_DLE) begin
                  frame_in[6] = rcps_pkg::CH_DLE;
                  k = 4'd7;
               end
               frame_in[k] = job.src;
               frame_in[k + 4'd1] = rcps_pkg::BYTE_COUNT_FIELD;
               frame_in[k + 4'd2] = cks;
               frame_in[k + 4'd3] = rcps_pkg::CH_DLE;
               frame_in[k + 4'd4] = rcps_pkg::CH_ETX;
               info_in.valid = 1'b1;
               info_in.len = k + 4'd5;
               end_in = k + 4'd4;
            end
            default: begin
               busy_in = 1'b0;
            end
         endcase
      end
   end

   // Leading DLE of ACK/NAK counts as pos 0 of the prefix pair.
   always_comb begin
      pre_dle_in = pre_dle_ff;
      if (step && pre_ff) pre_dle_in = 1'b0;
      if (job_valid && job_ready) pre_dle_in = (job.kind != rcps_pkg::JOB_RESEND);
   end

   always_comb begin
      if (pre_ff) begin
         out_byte = pre_dle_ff ? rcps_pkg::CH_DLE : pre_b_ff;
         out_last = !pre_dle_ff && !send_frame_ff;
      end else begin
         out_byte = frame_ff[pos_ff];
         out_last = (pos_ff == end_ff);
      end
   end

   assign pre_hold = pre_ff && pre_dle_ff;

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
      pos_ff <= pos_in;
      end_ff <= end_in;
      pre_b_ff <= pre_b_in;
      send_frame_ff <= send_frame_in;
      if (reset) begin
         busy_ff <= 1'b0;
         pre_ff <= 1'b0;
         pre_dle_ff <= 1'b0;
         info_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         pre_ff <= (step && pre_hold) ? 1'b1 : pre_in;
         pre_dle_ff <= pre_dle_in;
         info_ff <= info_in;
      end
   end

`ifndef SYNTHESIS
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !pre_ff |-> pos_ff <= end_ff && end_ff <= 4'd11)
      else $error("frame position out of range");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !job_ready)
      else $error("job taken while busy");
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      step && out_last |=> !busy_ff || $past(job_valid && job_ready))
      else $error("run continues after last");
`endif

endmodule

// File: rtl/rcps_queue.sv
module rcps_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  rcps_pkg::job_type in_job,
   output logic              out_valid,
   input  logic              out_ready,
   output rcps_pkg::job_type out_job
);

   rcps_pkg::job_type mem_ff [2];
   logic [1:0] cnt_ff;
   logic       wp_ff, rp_ff;
   logic       push, pop;

   assign in_ready = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_job = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= in_job;
      if (reset) begin
         cnt_ff <= '0;
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
      end else begin
         if (push) wp_ff <= !wp_ff;
         if (pop) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

`ifndef SYNTHESIS
   a_cnt: assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue overflow");
   a_ptr: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0 || cnt_ff == 2'd2) |-> wp_ff == rp_ff)
      else $error("queue pointers out of step");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready && !push |=> $stable(out_job))
      else $error("head changed");
`endif

endmodule

// File: rtl/router_crosspoint_protocol_slave.sv
// Slave side of a DLE/STX-framed router control protocol. A request is one received byte;
// each byte produces zero to fourteen response bytes, tx_last marking the final one.
// The parser takes one request per cycle while its two-entry command queue has room;
// the emitter sends one response byte per cycle while rsp.ready holds and takes the next
// command only once idle after its final byte, so responses bound the sustained rate.
// Camera presence masks are written through the CSR port (index 0 low, 1 high); the user
// must write them only while idle, which the block itself does not enforce.
module router_crosspoint_protocol_slave (
   input logic      clock,
   input logic      reset,
   rcps_req_if.sink req,
   rcps_rsp_if.source rsp,
   rcps_csr_if.sink csr
);

   logic [63:0] mask_lo_ff, mask_hi_ff;
   logic              f_valid, f_ready, b_valid, b_ready;
   rcps_pkg::job_type f_job, b_job;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_lo_ff <= '0;
         mask_hi_ff <= '0;
      end else if (csr.valid) begin
         case (csr.index)
            rcps_pkg::CSR_MASK_LOW: mask_lo_ff <= csr.data;
            rcps_pkg::CSR_MASK_HIGH: mask_hi_ff <= csr.data;
            default: ;
         endcase
      end
   end

   rcps_front u_front (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready), .in_byte(req.rx_byte),
      .mask({mask_hi_ff, mask_lo_ff}),
      .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
   );

   rcps_queue u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_ready(f_ready), .in_job(f_job),
      .out_valid(b_valid), .out_ready(b_ready), .out_job(b_job)
   );

   rcps_back u_back (
      .clock, .reset,
      .job_valid(b_valid), .job_ready(b_ready), .job(b_job),
      .out_valid(rsp.valid), .out_ready(rsp.ready),
      .out_byte(rsp.tx_byte), .out_last(rsp.tx_last)
   );

endmodule
